### hw/rtl/erm_pkg.sv
// package with constants, types and functions of the euler rotation matrix builder
`timescale 1ns / 1ps
package erm_pkg;

  localparam int FracBitsDefault    = 14;
  localparam int CordicStepsDefault = 16;
  localparam int AngleW = 16;
  localparam int WorkW  = 34;
  localparam int ZW     = 34;
  localparam int FieldW = 16;
  localparam int MaxSteps = 32;
  localparam logic signed [WorkW-1:0] GainQ30 = 34'sd652032874;

  typedef logic signed [WorkW-1:0] work_t;

  typedef struct packed {
    logic                     neg;
    logic signed [WorkW-1:0]  x;
    logic signed [WorkW-1:0]  y;
    logic signed [ZW-1:0]     z;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_lookup(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      5'd23: v = 34'sh000000051;
      5'd24: v = 34'sh000000029;
      5'd25: v = 34'sh000000014;
      5'd26: v = 34'sh00000000A;
      5'd27: v = 34'sh000000005;
      5'd28: v = 34'sh000000003;
      5'd29: v = 34'sh000000001;
      5'd30: v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q30 product rounded half up
  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [2*WorkW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return work_t'(p >>> 30);
  endfunction

endpackage

### hw/rtl/erm_cordic_cell.sv
// one cordic iteration cell, registered, for all three angles
`timescale 1ns / 1ps
module erm_cordic_cell #(
  parameter int Step = 0
) (
  input  logic          clk,
  input  logic          en,
  input  erm_pkg::rot_t in_p,
  input  erm_pkg::rot_t in_r,
  input  erm_pkg::rot_t in_y,
  output erm_pkg::rot_t out_p,
  output erm_pkg::rot_t out_r,
  output erm_pkg::rot_t out_y
);

  localparam logic [4:0] Idx = 5'(Step);

  erm_pkg::rot_t p_r, r_r, y_r;

  function automatic erm_pkg::rot_t rot_step(input erm_pkg::rot_t a);
    erm_pkg::rot_t b;
    erm_pkg::work_t dx, dy;
    b = a;
    dx = a.y >>> Step;
    dy = a.x >>> Step;
    if (!a.z[erm_pkg::ZW-1]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - erm_pkg::atan_lookup(Idx);
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + erm_pkg::atan_lookup(Idx);
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= rot_step(in_p);
      r_r <= rot_step(in_r);
      y_r <= rot_step(in_y);
    end
  end

  assign out_p = p_r;
  assign out_r = r_r;
  assign out_y = y_r;

endmodule

### hw/rtl/erm_matrix.sv
// product stages forming and rounding the nine matrix entries
`timescale 1ns / 1ps
module erm_matrix #(
  parameter int FracBits = erm_pkg::FracBitsDefault
) (
  input  logic          clk,
  input  logic          en,
  input  erm_pkg::rot_t rp,
  input  erm_pkg::rot_t rr,
  input  erm_pkg::rot_t ry,
  output logic [9*erm_pkg::FieldW-1:0] mat
);

  localparam int Sh = 30 - FracBits;
  localparam erm_pkg::work_t Lim = erm_pkg::work_t'(64'sd1 <<< FracBits);
  localparam erm_pkg::work_t Half = (Sh > 0) ? erm_pkg::work_t'(64'sd1 <<< (Sh - 1)) : '0;

  erm_pkg::work_t sp_r, cp_r, sr_r, cr_r, sy_r, cy_r;
  erm_pkg::work_t spsr_r, spcr_r, cycr_r, sycp_r, cysr_r, sycr_r, cycp_r, sysr_r, cpsr_r, cpcr_r;
  erm_pkg::work_t sp2_r, sy2_r, cy2_r;
  erm_pkg::work_t e_r [9];
  logic [9*erm_pkg::FieldW-1:0] mat_r;

  function automatic logic [erm_pkg::FieldW-1:0] finish(input erm_pkg::work_t v);
    erm_pkg::work_t t;
    t = (v + Half) >>> Sh;
    if (t > Lim) t = Lim;
    if (t < -Lim) t = -Lim;
    return t[erm_pkg::FieldW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r <= rp.neg ? -rp.y : rp.y;
      cp_r <= rp.neg ? -rp.x : rp.x;
      sr_r <= rr.neg ? -rr.y : rr.y;
      cr_r <= rr.neg ? -rr.x : rr.x;
      sy_r <= ry.neg ? -ry.y : ry.y;
      cy_r <= ry.neg ? -ry.x : ry.x;
      spsr_r <= erm_pkg::mulq(sp_r, sr_r);
      spcr_r <= erm_pkg::mulq(sp_r, cr_r);
      cycr_r <= erm_pkg::mulq(cy_r, cr_r);
      sycp_r <= erm_pkg::mulq(sy_r, cp_r);
      cysr_r <= erm_pkg::mulq(cy_r, sr_r);
      sycr_r <= erm_pkg::mulq(sy_r, cr_r);
      cycp_r <= erm_pkg::mulq(cy_r, cp_r);
      sysr_r <= erm_pkg::mulq(sy_r, sr_r);
      cpsr_r <= erm_pkg::mulq(cp_r, sr_r);
      cpcr_r <= erm_pkg::mulq(cp_r, cr_r);
      sp2_r <= sp_r;
      sy2_r <= sy_r;
      cy2_r <= cy_r;
      e_r[0] <= cycr_r - erm_pkg::mulq(sy2_r, spsr_r);
      e_r[1] <= -sycp_r;
      e_r[2] <= cysr_r + erm_pkg::mulq(sy2_r, spcr_r);
      e_r[3] <= sycr_r + erm_pkg::mulq(cy2_r, spsr_r);
      e_r[4] <= cycp_r;
      e_r[5] <= sysr_r - erm_pkg::mulq(cy2_r, spcr_r);
      e_r[6] <= -cpsr_r;
      e_r[7] <= sp2_r;
      e_r[8] <= cpcr_r;
      for (int k = 0; k < 9; k++) begin
        mat_r[k*erm_pkg::FieldW +: erm_pkg::FieldW] <= finish(e_r[k]);
      end
    end
  end

  assign mat = mat_r;

endmodule

### hw/rtl/euler_rotation_matrix_builder.sv
// top level of the euler angle rotation matrix builder
`timescale 1ns / 1ps
// usage:
//   input channel in_*: one transfer carries pitch, roll and yaw binary
//   angles (full turn 65536) packed in in_tdata.
//   output channel out_*: one transfer per input carries the nine entries
//   of R = yaw * pitch * roll, signed q1.14, row by row in out_tdata.
// throughput: one item per cycle unless stalled, set by the chain of cordic cells, one
//   cell per iteration for all three angles, followed by the product stages.
// pipeline: the input transfer passes the cordic cells (CORDIC_STEPS,
//   capped at 32), then four product stages, before output valid.
// stall: the whole pipe advances only while out_tready is high or the
//   output slot is empty; in_tready follows that same enable, so a stalled
//   receiver holds every stage and no item is lost.
// reset: rst_n low clears all valid flags; payload is left as is.
module euler_rotation_matrix_builder #(
  parameter int FRAC_BITS    = erm_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = erm_pkg::CordicStepsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // pitch_angle, roll_angle, yaw_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int Steps = (CORDIC_STEPS > erm_pkg::MaxSteps) ? erm_pkg::MaxSteps : CORDIC_STEPS;
  localparam int Lat = Steps + 4;

  logic en;
  logic [Lat-1:0] vld_r;
  erm_pkg::rot_t cp [Steps+1];
  erm_pkg::rot_t cr [Steps+1];
  erm_pkg::rot_t cy [Steps+1];

  function automatic erm_pkg::rot_t seed(input logic signed [erm_pkg::AngleW-1:0] a);
    erm_pkg::rot_t s;
    logic signed [erm_pkg::AngleW:0] w;
    w = {a[erm_pkg::AngleW-1], a};
    s.neg = 1'b0;
    if (w > 17'sd16384) begin
      w = w - 17'sd32768;
      s.neg = 1'b1;
    end else if (w < -17'sd16384) begin
      w = w + 17'sd32768;
      s.neg = 1'b1;
    end
    s.x = erm_pkg::GainQ30;
    s.y = '0;
    s.z = {w[erm_pkg::AngleW], w, 16'd0};
    return s;
  endfunction

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  assign cp[0] = seed(in_tdata[15:0]);
  assign cr[0] = seed(in_tdata[31:16]);
  assign cy[0] = seed(in_tdata[47:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    erm_cordic_cell #(.Step(g)) u_cell (
      .clk(clk), .en(en),
      .in_p(cp[g]), .in_r(cr[g]), .in_y(cy[g]),
      .out_p(cp[g+1]), .out_r(cr[g+1]), .out_y(cy[g+1])
    );
  end

  erm_matrix #(.FracBits(FRAC_BITS)) u_matrix (
    .clk(clk), .en(en),
    .rp(cp[Steps]), .rr(cr[Steps]), .ry(cy[Steps]),
    .mat(out_tdata)
  );

endmodule

### hw/rtl/erm_checker.sv
// port-level checker for the euler rotation matrix builder
`timescale 1ns / 1ps
module erm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");

  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input blocked while pipe can advance");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind euler_rotation_matrix_builder erm_checker u_erm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
